>>> src/bqrm_pkg.sv
package bqrm_pkg;

    localparam int MAX_DEPTH  = 64;
    localparam int ADDR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SLOT_W     = ADDR_W + 1;
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int HEIGHT_W   = 16;
    localparam int TAG_W      = 8;
    localparam int SUM_W      = HEIGHT_W + ADDR_W;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int CAP_W      = 7;
    localparam int CAP_RESET  = 5;
    localparam int ENTRY_W    = HEIGHT_W + TAG_W;

    // Stream payload layout.
    localparam int IN_TDATA_W   = ((HEIGHT_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_MEAN_LSB = 0;
    localparam int OUT_RH_LSB   = OUT_MEAN_LSB + HEIGHT_W;
    localparam int OUT_RT_LSB   = OUT_RH_LSB + HEIGHT_W;
    localparam int OUT_OCC_LSB  = OUT_RT_LSB + TAG_W;
    localparam int OUT_TDATA_W  = ((OUT_OCC_LSB + CNT_W + 7) / 8) * 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [HEIGHT_W-1:0] t_height;
    typedef logic [TAG_W-1:0]    t_tag;
    typedef logic [SUM_W-1:0]    t_sum;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the incoming transaction
        logic rd;        // read the oldest entry
        logic pop;       // retire the oldest entry
        logic write;     // append the new entry and start the divider
        logic div_step;  // one quotient bit
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;      // latched operation
        logic evict;     // queue is at or above capacity
        logic empty;     // queue holds nothing
        logic div_last;  // final quotient bit in progress
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

>>> src/bqrm_ram.sv
module bqrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/bqrm_ctrl.sv
module bqrm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_kind,
    input  bqrm_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output bqrm_pkg::t_cmd  o_cmd
);
    import bqrm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.latch    = accept;
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.pop      = (r_state == S_POP);
        o_cmd.write    = (r_state == S_WRITE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_DONE) && i_sts.out_free;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_kind == KIND_REMOVE) begin
                        n_state = i_sts.empty ? S_DONE : S_READ;
                    end else begin
                        n_state = i_sts.evict ? S_READ : S_WRITE;
                    end
                end
            end
            S_READ:  n_state = S_POP;
            S_POP:   n_state = (i_sts.kind == KIND_REMOVE) ? S_DONE : S_WRITE;
            S_WRITE: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/bqrm_dp.sv
module bqrm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bqrm_pkg::CAP_W-1:0]        i_cfg_wr_data,
    input  logic                              i_in_kind,
    input  logic [bqrm_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  logic                              i_out_ready,
    input  bqrm_pkg::t_cmd                    i_cmd,
    output bqrm_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output logic [bqrm_pkg::OUT_TDATA_W-1:0]  o_out_data,
    output logic                              o_out_user
);
    import bqrm_pkg::*;

    // Control state.
    logic [CAP_W-1:0] r_capacity;
    t_addr            r_head;
    t_cnt             r_count;
    t_sum             r_sum;
    logic             r_out_valid;

    // Per-transaction payload.
    logic             r_kind;
    logic             r_empty;
    t_height          r_height;
    t_tag             r_tag;
    t_height          r_rm_height;
    t_tag             r_rm_tag;

    // Divider.
    t_cnt             r_rem;
    t_sum             r_quo;
    logic [STEP_W-1:0] r_step;

    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    t_cnt                 eff_cap;
    logic [SLOT_W-1:0]    slot_sum;
    t_addr                wr_slot;
    t_addr                head_next;
    logic [ENTRY_W-1:0]   rd_entry;
    t_height              rd_height;
    t_tag                 rd_tag;
    t_sum                 sum_add;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_diff;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // Capacity zero acts as one; anything beyond the store saturates.
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(r_capacity) > MAX_DEPTH) begin
            eff_cap = CNT_W'(MAX_DEPTH);
        end else begin
            eff_cap = CNT_W'(r_capacity);
        end
    end

    always_comb begin
        slot_sum = SLOT_W'(r_head) + SLOT_W'(r_count);
        if (slot_sum >= SLOT_W'(MAX_DEPTH)) begin
            slot_sum = slot_sum - SLOT_W'(MAX_DEPTH);
        end
        wr_slot = slot_sum[ADDR_W-1:0];
        head_next = (r_head == ADDR_W'(MAX_DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);
    end

    bqrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (wr_slot),
        .i_wr_data ({r_tag, r_height}),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_head),
        .o_rd_data (rd_entry)
    );

    assign rd_height = rd_entry[HEIGHT_W-1:0];
    assign rd_tag    = rd_entry[ENTRY_W-1:HEIGHT_W];
    assign sum_add   = r_sum + SUM_W'(r_height);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_diff = trial - {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_W'(CAP_RESET);
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_cmd.pop) begin
                r_sum   <= r_sum - SUM_W'(rd_height);
                r_head  <= head_next;
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.write) begin
                r_sum   <= sum_add;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind      <= i_in_kind;
            r_empty     <= (i_in_kind == KIND_REMOVE) && (r_count == '0);
            r_height    <= i_in_data[HEIGHT_W-1:0];
            r_tag       <= i_in_data[HEIGHT_W+TAG_W-1:HEIGHT_W];
            r_rm_height <= '0;
            r_rm_tag    <= '0;
        end
        if (i_cmd.pop && (r_kind == KIND_REMOVE)) begin
            r_rm_height <= rd_height;
            r_rm_tag    <= rd_tag;
        end
        if (i_cmd.write) begin
            r_rem  <= '0;
            r_quo  <= sum_add;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial_diff[CNT_W]) begin
                r_rem <= trial_diff[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
            r_out_user <= r_empty;
        end
    end

    always_comb begin
        n_out_data = '0;
        if (r_kind == KIND_INSERT) begin
            n_out_data[OUT_MEAN_LSB +: HEIGHT_W] = r_quo[HEIGHT_W-1:0];
        end
        n_out_data[OUT_RH_LSB +: HEIGHT_W] = r_rm_height;
        n_out_data[OUT_RT_LSB +: TAG_W]    = r_rm_tag;
        n_out_data[OUT_OCC_LSB +: CNT_W]   = r_count;
    end

    always_comb begin
        o_sts          = '0;
        o_sts.kind     = r_kind;
        o_sts.evict    = (r_count >= eff_cap);
        o_sts.empty    = (r_count == '0);
        o_sts.div_last = (r_step == STEP_W'(SUM_W - 1));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

>>> src/bounded_queue_running_mean_unit.sv
// Channel   Direction  Handshake                      Contents
// config    in         i_cfg_wr_en                    i_cfg_wr_data: queue capacity
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: height, tag; tuser: kind
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: mean, removed entry, occupancy
//
// Transactions are handled one at a time. An insert writes the store, then the 22-step
// restoring divider forms the mean; an eviction first reads and pops the oldest entry. A
// remove does the registered read of the entry store and pops the entry, and a remove on
// an empty queue goes straight to the result register. The input is ready again in the
// cycle after the result is loaded. Reset is synchronous and active low; the store itself
// is not cleared. A result waits in the output register while the consumer stalls, and
// the block holds its next result until that register is free.
module bounded_queue_running_mean_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bqrm_pkg::CAP_W-1:0]        i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] height, [23:16] record_tag
    input  logic [bqrm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] mean_height, [31:16] removed_height, [39:32] removed_tag,
    // [46:40] occupancy, upper bits zero
    output logic [bqrm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] was_empty
    output logic                              m_axis_tuser
);
    import bqrm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences each transaction; the datapath holds the queue state,
    // the entry store, the divider and the output register.
    bqrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    bqrm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_kind     (s_axis_tuser),
        .i_in_data     (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_user    (m_axis_tuser)
    );

endmodule

>>> verif/tb_bounded_queue_running_mean_unit.sv
module tb_bounded_queue_running_mean_unit;

    import bqrm_pkg::*;

    // The clock period is 10 units. This ceiling only catches a block that has stopped
    // answering.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles allowed after the last result for anything unexpected to turn up.
    localparam int DRAIN_CYCLES = 40;

    // How the heights of a random phase are chosen.
    typedef enum int {
        HM_FULL,
        HM_EXTREME,
        HM_SMALL
    } t_height_mix;

    // One result transaction, field by field.
    typedef struct packed {
        t_height mean_height;
        t_height removed_height;
        t_tag    removed_tag;
        logic    was_empty;
        t_cnt    occupancy;
    } t_queue_result;

    // The scoreboard keeps its own copy of the queue, the running sum and the capacity.
    // Every accepted input transaction is applied to that copy, and the result it must
    // produce is queued. Every accepted output transaction is compared with the oldest
    // queued result.
    class mean_scoreboard;
        t_height         heights[MAX_DEPTH];
        t_tag            tags[MAX_DEPTH];
        int              head;
        int              count;
        int              sum;
        logic [CAP_W-1:0] capacity;
        t_queue_result   awaited[$];
        int              error_count;

        function new();
            head        = 0;
            count       = 0;
            sum         = 0;
            capacity    = CAP_W'(CAP_RESET);
            error_count = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void drop_oldest();
            sum   -= int'(heights[head]);
            head   = (head + 1) % MAX_DEPTH;
            count -= 1;
        endfunction

        function void note_input(logic kind, t_height height, t_tag tag);
            t_queue_result r;
            int            limit;
            int            slot;
            r = '0;
            // A capacity of zero behaves as one, and anything above the store depth
            // saturates at the depth.
            limit = int'(capacity);
            if (limit == 0) begin
                limit = 1;
            end
            if (limit > MAX_DEPTH) begin
                limit = MAX_DEPTH;
            end
            if (kind == KIND_INSERT) begin
                // A full queue loses exactly one oldest entry, even when the capacity has
                // been lowered below the present occupancy.
                if (count >= limit && count > 0) begin
                    drop_oldest();
                end
                slot          = (head + count) % MAX_DEPTH;
                heights[slot] = height;
                tags[slot]    = tag;
                sum          += int'(height);
                count        += 1;
                r.mean_height = t_height'(sum / count);
            end else if (count > 0) begin
                r.removed_height = heights[head];
                r.removed_tag    = tags[head];
                drop_oldest();
            end else begin
                r.was_empty = 1'b1;
            end
            r.occupancy = t_cnt'(count);
            awaited.push_back(r);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            error_count++;
        endtask

        task compare(string name, int got, int want);
            if (got != want) begin
                report($sformatf("%s is %0d, expected %0d", name, got, want));
            end
        endtask

        task check_result(t_queue_result got);
            t_queue_result want;
            if (awaited.size() == 0) begin
                report("result transaction with no input transaction awaiting one");
            end else begin
                want = awaited.pop_front();
                compare("mean_height", got.mean_height, want.mean_height);
                compare("removed_height", got.removed_height, want.removed_height);
                compare("removed_tag", got.removed_tag, want.removed_tag);
                compare("was_empty", got.was_empty, want.was_empty);
                compare("occupancy", got.occupancy, want.occupancy);
            end
        endtask
    endclass

    // Every input of the block holds a known value from time zero onwards.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] height, [23:16] record_tag
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [0] kind
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] mean_height, [31:16] removed_height, [39:32] removed_tag, [46:40] occupancy
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] was_empty
    logic                   m_axis_tuser;

    mean_scoreboard sb;
    int             cycles    = 0;
    // When set, neither the sender nor the receiver leaves any gap.
    bit             gaps_off  = 1'b0;

    bounded_queue_running_mean_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The watchdog. It only fires if the block stops answering altogether.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("bounded_queue_running_mean_unit test failed");
            $finish;
        end
    end

    // Everything is observed at the rising edge. Inputs only change at the falling edge,
    // so the values seen here are the ones the block itself samples. A configuration
    // write is applied to the scoreboard at the same edge that the block takes it.
    always @(posedge i_clk) begin
        t_queue_result seen;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                sb.set_capacity(i_cfg_wr_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_input(s_axis_tuser, s_axis_tdata[HEIGHT_W-1:0],
                              s_axis_tdata[HEIGHT_W +: TAG_W]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.mean_height    = m_axis_tdata[OUT_MEAN_LSB +: HEIGHT_W];
                seen.removed_height = m_axis_tdata[OUT_RH_LSB +: HEIGHT_W];
                seen.removed_tag    = m_axis_tdata[OUT_RT_LSB +: TAG_W];
                seen.was_empty      = m_axis_tuser;
                seen.occupancy      = m_axis_tdata[OUT_OCC_LSB +: CNT_W];
                sb.check_result(seen);
            end
        end
    end

    // Gap before each transaction, drawn afresh for every one on both sides.
    function automatic int draw_gap();
        if (gaps_off) begin
            return 0;
        end
        return int'($urandom_range(0, 14));
    endfunction

    // Sends one input transaction. It is entered and left at a falling edge, and tvalid
    // is assigned once at most in any one step, so back-to-back transactions keep it high.
    task automatic send(logic kind, t_height height, t_tag tag);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_TDATA_W'({tag, height});
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // The capacity is only changed once every result owed has been collected. Each
    // transaction yields exactly one result, so the block is idle at that point.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // A run of random transactions. The share of inserts steers the occupancy: a high
    // share keeps the queue full and evicting, a low share keeps it draining to empty.
    task automatic run_phase(int items, int insert_pct, t_height_mix mix);
        int      i;
        logic    kind;
        t_height height;
        for (i = 0; i < items; i++) begin
            kind = ($urandom_range(1, 100) <= insert_pct) ? KIND_INSERT : KIND_REMOVE;
            case (mix)
                HM_EXTREME: begin
                    height = ($urandom_range(0, 4) == 0) ? '0 : '1;
                end
                HM_SMALL: begin
                    height = t_height'($urandom_range(0, 15));
                end
                default: begin
                    height = t_height'($urandom);
                end
            endcase
            send(kind, height, t_tag'($urandom));
        end
    endtask

    // The consumer holds tready low for a random number of cycles before each result,
    // then waits with it high until the result has been taken.
    initial begin
        int stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the capacity still at its reset value of five. A remove on
        // the empty queue comes first, then the heights and tags at their extremes, then
        // enough inserts to force two evictions, then removes until the queue is empty
        // once more.
        send(KIND_REMOVE, 16'h0000, 8'h00);
        send(KIND_INSERT, 16'h0000, 8'h00);
        send(KIND_INSERT, 16'hFFFF, 8'hFF);
        send(KIND_INSERT, 16'hFFFF, 8'hAA);
        send(KIND_INSERT, 16'h0001, 8'h55);
        send(KIND_INSERT, 16'h8000, 8'h0F);
        send(KIND_INSERT, 16'h5555, 8'hF0);
        send(KIND_INSERT, 16'hAAAA, 8'h01);
        repeat (6) send(KIND_REMOVE, 16'hFFFF, 8'hFF);

        // A capacity of one: every insert after the first evicts.
        write_capacity(7'd1);
        send(KIND_INSERT, 16'h1234, 8'h12);
        send(KIND_INSERT, 16'h4321, 8'h34);
        send(KIND_REMOVE, 16'h0000, 8'h00);
        send(KIND_REMOVE, 16'h0000, 8'h00);

        // A capacity of zero must behave as one.
        write_capacity(7'd0);
        send(KIND_INSERT, 16'hFFFF, 8'h80);
        send(KIND_INSERT, 16'h7FFF, 8'h7F);
        send(KIND_REMOVE, 16'h0000, 8'h00);

        // Random part. The capacity is changed between phases without draining the queue,
        // so later phases start with the occupancy above the new capacity. The first phase
        // saturates the capacity at the store depth and fills it mostly with the largest heights,
        // which pushes the running sum towards its widest value.
        write_capacity(7'd127);
        run_phase(70, 90, HM_EXTREME);
        write_capacity(7'd64);
        run_phase(60, 70, HM_FULL);
        gaps_off = 1'b1;
        write_capacity(7'd3);
        run_phase(60, 50, HM_FULL);
        write_capacity(7'd1);
        run_phase(50, 60, HM_SMALL);
        gaps_off = 1'b0;
        write_capacity(7'd0);
        run_phase(50, 50, HM_FULL);
        write_capacity(7'd2);
        run_phase(60, 30, HM_FULL);
        write_capacity(CAP_W'($urandom_range(4, 63)));
        run_phase(60, 55, HM_FULL);
        gaps_off = 1'b1;
        write_capacity(7'd64);
        run_phase(70, 95, HM_EXTREME);
        write_capacity(7'd17);
        run_phase(60, 30, HM_SMALL);
        gaps_off = 1'b0;
        write_capacity(7'd100);
        run_phase(60, 65, HM_FULL);
        write_capacity(7'd5);
        run_phase(60, 50, HM_FULL);
        write_capacity(CAP_W'($urandom_range(1, 127)));
        run_phase(60, 60, HM_FULL);

        // Wait for every owed result, then leave room for any stray one to show up.
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.error_count == 0) begin
            $display("bounded_queue_running_mean_unit test passed");
        end else begin
            $display("bounded_queue_running_mean_unit test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/bqrm_pkg.sv
src/bqrm_ram.sv
src/bqrm_ctrl.sv
src/bqrm_dp.sv
src/bounded_queue_running_mean_unit.sv
verif/tb_bounded_queue_running_mean_unit.sv
